/* hw/rtl/median_3x3_bgra_filter_macros.svh */
// Assertion macros used by the checker file.
`ifndef MEDIAN_3X3_BGRA_FILTER_MACROS_SVH
`define MEDIAN_3X3_BGRA_FILTER_MACROS_SVH

// Property checked outside reset.
`define MF3_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked on every edge, reset included.
`define MF3_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* hw/rtl/mf3_pkg.sv */
`timescale 1ns / 1ps

package mf3_pkg;

   localparam int PIX_W     = 32;
   localparam int CH_W      = 8;
   localparam int ROW_OUT_W = 12;
   localparam int COL_OUT_W = 11;

   // Packed BGRA pixel: blue [7:0], green [15:8], red [23:16], alpha [31:24]
   typedef logic [PIX_W-1:0] pix_type;

   // One window column: [0] oldest row, [1] middle row, [2] newest row
   typedef pix_type [2:0] column_type;

   // Nine samples of one neighbourhood
   typedef pix_type [8:0] nine_type;

   // Side information that rides along with each result
   typedef struct packed {
      logic [CH_W-1:0]      alpha;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic                 frame_done;
      logic                 run_end;
   } info_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } median_type;

   // Which of the up to four results of one request is being issued
   typedef enum logic [1:0] {
      STEP_PREV_IN   = 2'b00,
      STEP_PREV_EDGE = 2'b01,
      STEP_LAST_IN   = 2'b10,
      STEP_LAST_EDGE = 2'b11
   } step_type;

endpackage

/* hw/rtl/mf3_line_mem.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read data.
module mf3_line_mem #(
   parameter int  DEPTH  = 2048,
   parameter int  DATA_W = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] line_ram [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/mf3_median9.sv */
`timescale 1ns / 1ps

// Three-stage median of nine for B, G and R, elastic with valid/ready.
// Stage 1 sorts each group of three, stage 2 takes max of mins, median of
// middles and min of maxes, stage 3 takes the median of those three.
module mf3_median9 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mf3_pkg::nine_type    in_pix,
   input  mf3_pkg::info_type    in_info,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mf3_pkg::median_type  out_med,
   output mf3_pkg::info_type    out_info
);

   // [channel][group][rank], rank 0 is the smallest
   logic [2:0][2:0][2:0][7:0] s1_sort_ff, s1_sort_in;
   // [channel][lo, mid, hi]
   logic [2:0][2:0][7:0]      s2_cand_ff, s2_cand_in;
   logic [2:0][7:0]           s3_med_in;

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   mf3_pkg::info_type         s1_info_ff, s2_info_ff, s3_info_ff;
   mf3_pkg::median_type       s3_med_ff;
   logic                      adv1, adv2, adv3;

   function automatic logic [2:0][7:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic [7:0]      lo;
      logic [7:0]      hi;
      logic [2:0][7:0] res;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c < lo) begin
         res = {hi, lo, c};
      end else if (c > hi) begin
         res = {c, hi, lo};
      end else begin
         res = {hi, c, lo};
      end
      return res;
   endfunction

   // Stage advance chain from the output back
   assign adv3     = !s3_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // Sort groups of three
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int g = 0; g < 3; g++) begin
            s1_sort_in[ch][g] = sort3(in_pix[3*g][8*ch +: 8], in_pix[3*g+1][8*ch +: 8],
                                      in_pix[3*g+2][8*ch +: 8]);
         end
      end
   end

   // Reduce to three candidates
   always_comb begin
      logic [2:0][7:0] lo_s, mid_s, hi_s;
      for (int ch = 0; ch < 3; ch++) begin
         lo_s  = sort3(s1_sort_ff[ch][0][0], s1_sort_ff[ch][1][0], s1_sort_ff[ch][2][0]);
         mid_s = sort3(s1_sort_ff[ch][0][1], s1_sort_ff[ch][1][1], s1_sort_ff[ch][2][1]);
         hi_s  = sort3(s1_sort_ff[ch][0][2], s1_sort_ff[ch][1][2], s1_sort_ff[ch][2][2]);
         s2_cand_in[ch][0] = lo_s[2];
         s2_cand_in[ch][1] = mid_s[1];
         s2_cand_in[ch][2] = hi_s[0];
      end
   end

   // Final median of three
   always_comb begin
      logic [2:0][7:0] fin_s;
      for (int ch = 0; ch < 3; ch++) begin
         fin_s = sort3(s2_cand_ff[ch][0], s2_cand_ff[ch][1], s2_cand_ff[ch][2]);
         s3_med_in[ch] = fin_s[1];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= in_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_sort_ff <= s1_sort_in;
         s1_info_ff <= in_info;
      end
      if (adv2) begin
         s2_cand_ff <= s2_cand_in;
         s2_info_ff <= s1_info_ff;
      end
      if (adv3) begin
         s3_med_ff.blue  <= s3_med_in[0];
         s3_med_ff.green <= s3_med_in[1];
         s3_med_ff.red   <= s3_med_in[2];
         s3_info_ff      <= s2_info_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_med   = s3_med_ff;
   assign out_info  = s3_info_ff;

endmodule

/* hw/rtl/median_3x3_bgra_filter.sv */
`timescale 1ns / 1ps

// 3x3 median filter for a raster stream of BGRA pixels. A request is taken
// every clock unless it yields more than one result or the result port
// stalls. From row 1 on, the last column of a row yields two results. On the
// last row of the frame every request from column 1 on yields two, and the
// last one of the frame yields four. The result port delivers one per clock
// while not stalled, as the median pipeline has a single result path, so the
// window waits on such a request until all its results are issued.
// The first result of a request passes through line memory read, window load
// and three median stages, and the last of these drives the port. Both previous
// rows sit in one 64-bit wide line memory that is read and written back once
// per request; it is not cleared after reset, as a frame only reads columns it
// has written. Results lag by one row and one column and carry their row and
// column; border rows and columns are replicated and alpha is taken from the
// centre pixel. Writing either size register restarts the frame at row 0,
// column 0; sizes are clamped to 3 .. MAX_WIDTH and 3 .. MAX_HEIGHT.
module median_3x3_bgra_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_alpha,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_alpha,
   output logic [11:0] rsp_out_row,
   output logic [10:0] rsp_out_col,
   output logic        rsp_frame_done,
   output logic        rsp_run_end,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int ROW_OUT_W = mf3_pkg::ROW_OUT_W;
   localparam int COL_OUT_W = mf3_pkg::COL_OUT_W;

   localparam logic        REG_LINE_WIDTH   = 1'b0;
   localparam logic        REG_FRAME_HEIGHT = 1'b1;
   localparam logic [11:0] LINE_WIDTH_RST   = 12'd1920;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;

   // registers
   logic [11:0]          line_width_ff;
   logic [12:0]          frame_height_ff;
   logic                 cfg_write;
   logic [COL_W-1:0]     w_last;
   logic [ROW_W-1:0]     h_last;

   // position counters
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 req_accept;
   logic                 at_last_col, at_last_row;

   // memory stage
   logic                 s1_valid_ff;
   mf3_pkg::pix_type     s1_px_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic                 s1_last_col_ff, s1_last_row_ff;
   logic                 s1_move;
   logic [63:0]          mem_rd_data;
   logic [63:0]          mem_wr_data;
   mf3_pkg::pix_type     rd_older, rd_newer;

   // window and result sequencer
   mf3_pkg::column_type  win_ff [3];
   logic                 job_valid_ff;
   logic [COL_W-1:0]     job_col_ff;
   logic [ROW_W-1:0]     job_row_ff;
   logic                 job_last_col_ff, job_last_row_ff;
   logic                 job_top_ff, job_left_ff;
   mf3_pkg::step_type    step_ff, step_in;
   logic                 step_last;
   logic                 sel_edge, sel_bottom;
   logic                 issue, job_done;

   // median pipeline
   logic                 med_in_ready;
   mf3_pkg::nine_type    med_pix;
   mf3_pkg::info_type    med_info;
   mf3_pkg::median_type  med_out;
   mf3_pkg::info_type    med_out_info;
   mf3_pkg::column_type  col_a, col_b, col_c, col_mid;
   logic [ROW_W-1:0]     res_row;
   logic [COL_W-1:0]     res_col;

   // Rows of one column, with the border row replicated
   function automatic mf3_pkg::pix_type [2:0] pick_rows(input mf3_pkg::column_type col,
                                                        input logic bottom,
                                                        input logic top);
      mf3_pkg::pix_type [2:0] res;
      res[0] = (bottom || top) ? col[1] : col[0];
      res[1] = bottom ? col[2] : col[1];
      res[2] = col[2];
      return res;
   endfunction

   // ---------------- register port ----------------
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (cfg_write) begin
         case (csr_paddr[2])
            REG_LINE_WIDTH:   line_width_ff   <= csr_pwdata[11:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[12:0];
            default:          line_width_ff   <= line_width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_LINE_WIDTH:   csr_prdata = 32'(line_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Clamped last column and last row
   always_comb begin
      if (line_width_ff < 12'd3) begin
         w_last = COL_W'(2);
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(line_width_ff - 12'd1);
      end
      if (frame_height_ff < 13'd3) begin
         h_last = ROW_W'(2);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(frame_height_ff - 13'd1);
      end
   end

   // ---------------- raster position ----------------
   assign req_ready   = !s1_valid_ff || s1_move;
   assign req_accept  = req_valid && req_ready;
   assign at_last_col = (col_ff == w_last);
   assign at_last_row = (row_ff == h_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line memory read / write back ----------------
   assign rd_older    = mem_rd_data[63:32];
   assign rd_newer    = mem_rd_data[31:0];
   assign mem_wr_data = {rd_newer, s1_px_ff};

   mf3_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (64)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (mem_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff       <= {req_in_alpha, req_in_red, req_in_green, req_in_blue};
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= at_last_col;
         s1_last_row_ff <= at_last_row;
      end
   end

   // ---------------- window shift ----------------
   // The window only moves once the previous request's results are all issued
   assign issue    = job_valid_ff && med_in_ready;
   assign job_done = issue && step_last;
   assign s1_move  = s1_valid_ff && (!job_valid_ff || job_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         win_ff[2] <= '0;
      end else if (s1_move) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= {s1_px_ff, rd_newer, rd_older};
      end
   end

   // ---------------- result sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= mf3_pkg::STEP_PREV_IN;
      end else if (s1_move) begin
         job_valid_ff <= (s1_row_ff != '0) && (s1_col_ff != '0);
         step_ff      <= mf3_pkg::STEP_PREV_IN;
      end else if (issue) begin
         job_valid_ff <= !step_last;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         job_col_ff      <= s1_col_ff;
         job_row_ff      <= s1_row_ff;
         job_last_col_ff <= s1_last_col_ff;
         job_last_row_ff <= s1_last_row_ff;
         job_top_ff      <= (s1_row_ff == ROW_W'(1));
         job_left_ff     <= (s1_col_ff == COL_W'(1));
      end
   end

   // Next step
   always_comb begin
      step_in   = mf3_pkg::STEP_PREV_IN;
      step_last = 1'b1;
      case (step_ff)
         mf3_pkg::STEP_PREV_IN: begin
            if (job_last_col_ff) begin
               step_in   = mf3_pkg::STEP_PREV_EDGE;
               step_last = 1'b0;
            end else if (job_last_row_ff) begin
               step_in   = mf3_pkg::STEP_LAST_IN;
               step_last = 1'b0;
            end
         end
         mf3_pkg::STEP_PREV_EDGE: begin
            if (job_last_row_ff) begin
               step_in   = mf3_pkg::STEP_LAST_IN;
               step_last = 1'b0;
            end
         end
         mf3_pkg::STEP_LAST_IN: begin
            if (job_last_col_ff) begin
               step_in   = mf3_pkg::STEP_LAST_EDGE;
               step_last = 1'b0;
            end
         end
         mf3_pkg::STEP_LAST_EDGE: begin
            step_last = 1'b1;
         end
         default: begin
            step_last = 1'b1;
         end
      endcase
   end

   // Step outputs: right edge column and bottom edge row selection
   always_comb begin
      case (step_ff)
         mf3_pkg::STEP_PREV_IN:   {sel_bottom, sel_edge} = 2'b00;
         mf3_pkg::STEP_PREV_EDGE: {sel_bottom, sel_edge} = 2'b01;
         mf3_pkg::STEP_LAST_IN:   {sel_bottom, sel_edge} = 2'b10;
         mf3_pkg::STEP_LAST_EDGE: {sel_bottom, sel_edge} = 2'b11;
         default:                 {sel_bottom, sel_edge} = 2'b00;
      endcase
   end

   // Neighbourhood with replicated borders
   always_comb begin
      col_a   = (sel_edge || job_left_ff) ? win_ff[1] : win_ff[0];
      col_b   = sel_edge ? win_ff[2] : win_ff[1];
      col_c   = win_ff[2];
      col_mid = col_b;
      med_pix = {pick_rows(col_c, sel_bottom, job_top_ff),
                 pick_rows(col_b, sel_bottom, job_top_ff),
                 pick_rows(col_a, sel_bottom, job_top_ff)};
      res_row = sel_bottom ? job_row_ff : job_row_ff - ROW_W'(1);
      res_col = sel_edge ? job_col_ff : job_col_ff - COL_W'(1);
      med_info.alpha      = sel_bottom ? col_mid[2][31:24] : col_mid[1][31:24];
      med_info.row        = ROW_OUT_W'(res_row);
      med_info.col        = COL_OUT_W'(res_col);
      med_info.frame_done = (step_ff == mf3_pkg::STEP_LAST_EDGE);
      med_info.run_end    = step_last;
   end

   // ---------------- median pipeline and result register ----------------
   mf3_median9 u_median9 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid_ff),
      .in_ready  (med_in_ready),
      .in_pix    (med_pix),
      .in_info   (med_info),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_med   (med_out),
      .out_info  (med_out_info)
   );

   assign rsp_out_blue   = med_out.blue;
   assign rsp_out_green  = med_out.green;
   assign rsp_out_red    = med_out.red;
   assign rsp_out_alpha  = med_out_info.alpha;
   assign rsp_out_row    = med_out_info.row;
   assign rsp_out_col    = med_out_info.col;
   assign rsp_frame_done = med_out_info.frame_done;
   assign rsp_run_end    = med_out_info.run_end;

endmodule

/* hw/rtl/mf3_checker.sv */
`timescale 1ns / 1ps
`include "median_3x3_bgra_filter_macros.svh"

// Port-level checks on the result channel.
module mf3_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_blue,
   input logic [7:0]  rsp_out_green,
   input logic [7:0]  rsp_out_red,
   input logic [7:0]  rsp_out_alpha,
   input logic [11:0] rsp_out_row,
   input logic [10:0] rsp_out_col,
   input logic        rsp_frame_done,
   input logic        rsp_run_end
);

   logic        rsp_stall;
   logic [56:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_alpha,
                         rsp_out_row, rsp_out_col, rsp_frame_done, rsp_run_end};

   // A stalled result holds
   `MF3_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_stall |=> rsp_valid && $stable(rsp_payload)), "result changed while stalled")
   // The bottom-right result is always the last one of its request
   `MF3_ASSERT_RST(a_done_ends_run, clock, reset, (rsp_valid && rsp_frame_done |-> rsp_run_end), "frame end without end of run")
   // Frames are at least three pixels each way
   `MF3_ASSERT_RST(a_done_coord, clock, reset, (rsp_valid && rsp_frame_done |-> rsp_out_row != 12'd0 && rsp_out_col != 11'd0), "frame end at first row or column")
   // Nothing pending right after a reset cycle
   `MF3_ASSERT(a_reset_empty, clock, (reset |=> !rsp_valid), "result valid after reset")

endmodule

bind median_3x3_bgra_filter mf3_checker u_mf3_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_blue   (rsp_out_blue),
   .rsp_out_green  (rsp_out_green),
   .rsp_out_red    (rsp_out_red),
   .rsp_out_alpha  (rsp_out_alpha),
   .rsp_out_row    (rsp_out_row),
   .rsp_out_col    (rsp_out_col),
   .rsp_frame_done (rsp_frame_done),
   .rsp_run_end    (rsp_run_end)
);
